// ===== rtl/core/sha1_digest_engine_core_macros.svh =====
// ----------------------------------------------------------------------------
// SHA-1 digest engine core assertion macros
// Concurrent assertion shorthands clocked on i_clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SHA1_DIGEST_ENGINE_CORE_MACROS_SVH
`define SHA1_DIGEST_ENGINE_CORE_MACROS_SVH

// Same-cycle implication.
`define SDE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SDE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sha1de_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-1 digest engine package
// Shared types, constants and helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sha1de_pkg;

    localparam int BUF_WORDS    = 16;
    localparam int CHAIN_WORDS  = 5;
    localparam int ROUNDS       = 80;
    localparam int LAST_PAD_WRD = 13;
    localparam int LEN_HI_WRD   = 14;
    localparam int LAST_BUF_WRD = 15;
    localparam int LONG_PAD_MIN = 56;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PADSET,
        S_PAD,
        S_LEN,
        S_LOADH,
        S_ROUND,
        S_ADD,
        S_OUT_RD,
        S_OUT_LD
    } t_state;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } t_abcde;

    function automatic logic [31:0] init_word(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = 32'h6745_2301;
            3'd1:    v = 32'hEFCD_AB89;
            3'd2:    v = 32'h98BA_DCFE;
            3'd3:    v = 32'h1032_5476;
            3'd4:    v = 32'hC3D2_E1F0;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

endpackage

// ===== rtl/core/sha1_digest_engine_core.sv =====
// ----------------------------------------------------------------------------
// SHA-1 digest engine core
// Byte-serial SHA-1: block buffer and chaining words held in small RAMs.
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | fields
//  --------+-----+------------------------+----------------------------------
//  in      | in  | i_in_valid/o_in_stall  | data_byte, byte_valid, end_of_msg
//  out     | out | o_out_valid/i_out_stall| digest_word, word_index, last_word
//
//  A filled block reads the five chain words, runs the 80 rounds, then does a
//  read-add-write of each chain word. End of message: pad words (into a second
//  block from 56 bytes on), length words 14 and 15 and a compression per block,
//  then a chain read and load per digest word. Input stall is high outside S_IDLE.
//  Reset is synchronous; the chain RAM reads as the initial hash until written.
//  The output register lets the next message start while word 4 waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sha1_digest_engine_core_macros.svh"

module sha1_digest_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_end_of_message,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import sha1de_pkg::*;

    t_state r_state, n_state;
    t_state r_ret, n_ret;

    logic [5:0]  r_fill;
    logic [60:0] r_total;
    logic [3:0]  r_widx;
    logic        r_first;
    logic        r_two;
    logic [2:0]  r_cnt;
    logic [6:0]  r_t;
    logic [2:0]  r_oidx;
    t_abcde      r_work;
    logic [31:0] r_w [BUF_WORDS];

    // block buffer RAM, byte-writable words, big-endian lanes
    logic [31:0] buf_mem [BUF_WORDS];
    logic [31:0] r_brd;
    // chaining RAM with per-entry valid bits
    logic [31:0] chain_mem [CHAIN_WORDS];
    logic [CHAIN_WORDS-1:0] r_cval;
    logic [31:0] r_crd;
    logic        r_crd_val;
    logic [2:0]  r_crd_idx;

    logic        r_out_valid;
    logic [31:0] r_digest_word;
    logic [2:0]  r_word_index;
    logic        r_last_word;

    logic        in_acc;
    logic        out_free;
    logic        pad_end;
    logic [31:0] h_eff;
    logic [31:0] work_sel;
    logic [31:0] w_t;
    logic [31:0] w_sched;
    logic [63:0] bit_len;
    t_abcde      round_next;

    logic        c_rd_en;
    logic [2:0]  c_rd_addr;
    logic        c_wr_en;
    logic        b_wr_en;
    logic [3:0]  b_wr_addr;
    logic [31:0] b_wr_data;
    logic [3:0]  b_wr_be;
    logic        b_rd_en;
    logic [3:0]  b_rd_addr;
    logic        out_load;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign pad_end    = (r_widx == (r_two ? 4'(LAST_BUF_WRD) : 4'(LAST_PAD_WRD)));
    assign bit_len    = {r_total, 3'b000};
    assign h_eff      = r_crd_val ? r_crd : init_word(r_crd_idx);

    always_comb begin
        case (r_crd_idx)
            3'd0:    work_sel = r_work.a;
            3'd1:    work_sel = r_work.b;
            3'd2:    work_sel = r_work.c;
            3'd3:    work_sel = r_work.d;
            default: work_sel = r_work.e;
        endcase
    end

    assign w_sched = rotl(r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0], 1);
    assign w_t     = (r_t < 7'(BUF_WORDS)) ? r_brd : w_sched;

    sha1de_round u_round (
        .i_cur   (r_work),
        .i_w     (w_t),
        .i_round (r_t),
        .o_next  (round_next)
    );

    // next state
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_byte_valid && (r_fill == 6'd63)) begin
                        n_state = S_LOADH;
                        n_ret   = i_end_of_message ? S_PADSET : S_IDLE;
                    end else if (i_end_of_message) begin
                        n_state = S_PADSET;
                    end
                end
            end
            S_PADSET: n_state = S_PAD;
            S_PAD: begin
                if (pad_end) begin
                    if (r_two) begin
                        n_state = S_LOADH;
                        n_ret   = S_PAD;
                    end else begin
                        n_state = S_LEN;
                    end
                end
            end
            S_LEN: begin
                if (r_widx == 4'(LAST_BUF_WRD)) begin
                    n_state = S_LOADH;
                    n_ret   = S_OUT_RD;
                end
            end
            S_LOADH: if (r_cnt == 3'(CHAIN_WORDS)) n_state = S_ROUND;
            S_ROUND: if (r_t == 7'(ROUNDS - 1)) n_state = S_ADD;
            S_ADD:   if (r_cnt == 3'(CHAIN_WORDS)) n_state = r_ret;
            S_OUT_RD: n_state = S_OUT_LD;
            S_OUT_LD: begin
                if (out_free) begin
                    n_state = (r_oidx == 3'(CHAIN_WORDS - 1)) ? S_IDLE : S_OUT_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory and output controls
    always_comb begin
        c_rd_en   = 1'b0;
        c_rd_addr = r_cnt;
        c_wr_en   = 1'b0;
        b_wr_en   = 1'b0;
        b_wr_addr = r_widx;
        b_wr_data = 32'h0;
        b_wr_be   = 4'b1111;
        b_rd_en   = 1'b0;
        b_rd_addr = 4'd0;
        out_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                b_wr_en   = in_acc && i_byte_valid;
                b_wr_addr = r_fill[5:2];
                b_wr_data = {4{i_data_byte}};
                b_wr_be   = 4'b1000 >> r_fill[1:0];
            end
            S_PAD: begin
                b_wr_en = 1'b1;
                if (r_first) begin
                    // 0x80 at the fill position, zeros after it, older bytes kept
                    b_wr_data = {PAD_BYTE, 24'h0} >> {r_fill[1:0], 3'b000};
                    b_wr_be   = 4'b1111 >> r_fill[1:0];
                end
            end
            S_LEN: begin
                b_wr_en   = 1'b1;
                b_wr_data = (r_widx == 4'(LEN_HI_WRD)) ? bit_len[63:32] : bit_len[31:0];
            end
            S_LOADH: begin
                c_rd_en = (r_cnt < 3'(CHAIN_WORDS));
                b_rd_en = (r_cnt == 3'(CHAIN_WORDS));
            end
            S_ROUND: begin
                b_rd_en   = (r_t < 7'(BUF_WORDS - 1));
                b_rd_addr = r_t[3:0] + 4'd1;
            end
            S_ADD: begin
                c_rd_en = (r_cnt < 3'(CHAIN_WORDS));
                c_wr_en = (r_cnt != 3'd0);
            end
            S_OUT_RD: begin
                c_rd_en   = 1'b1;
                c_rd_addr = r_oidx;
            end
            S_OUT_LD: out_load = out_free;
            default: ;
        endcase
    end

    // block buffer RAM; rounds never write it, so no read/write overlap
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            if (b_wr_en && b_wr_be[k]) begin
                buf_mem[b_wr_addr][8*k +: 8] <= b_wr_data[8*k +: 8];
            end
        end
        if (b_rd_en) begin
            r_brd <= buf_mem[b_rd_addr];
        end
    end

    // chain RAM: write entry idx while reading idx+1
    always_ff @(posedge i_clk) begin
        if (c_wr_en) begin
            chain_mem[r_crd_idx] <= h_eff + work_sel;
        end
        if (c_rd_en) begin
            r_crd     <= chain_mem[c_rd_addr];
            r_crd_idx <= c_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_fill      <= '0;
            r_total     <= '0;
            r_widx      <= '0;
            r_first     <= 1'b0;
            r_two       <= 1'b0;
            r_cnt       <= '0;
            r_t         <= '0;
            r_oidx      <= '0;
            r_cval      <= '0;
            r_crd_val   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            if (c_rd_en) begin
                r_crd_val <= r_cval[c_rd_addr];
            end
            if (c_wr_en) begin
                r_cval[r_crd_idx] <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && i_byte_valid) begin
                        r_fill  <= r_fill + 6'd1;
                        r_total <= r_total + 61'd1;
                    end
                end
                S_PADSET: begin
                    r_widx  <= r_fill[5:2];
                    r_first <= 1'b1;
                    r_two   <= (r_fill >= 6'(LONG_PAD_MIN));
                end
                S_PAD: begin
                    r_first <= 1'b0;
                    if (pad_end) begin
                        r_two  <= 1'b0;
                        r_widx <= r_two ? 4'd0 : 4'(LEN_HI_WRD);
                    end else begin
                        r_widx <= r_widx + 4'd1;
                    end
                end
                S_LEN: begin
                    r_widx <= r_widx + 4'd1;
                    r_oidx <= '0;
                end
                S_LOADH: begin
                    r_cnt <= (r_cnt == 3'(CHAIN_WORDS)) ? 3'd0 : r_cnt + 3'd1;
                    r_t   <= '0;
                end
                S_ROUND: r_t <= r_t + 7'd1;
                S_ADD: r_cnt <= (r_cnt == 3'(CHAIN_WORDS)) ? 3'd0 : r_cnt + 3'd1;
                S_OUT_LD: begin
                    if (out_free) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'(CHAIN_WORDS - 1)) begin
                            // back to the initial hash for the next message
                            r_cval  <= '0;
                            r_fill  <= '0;
                            r_total <= '0;
                        end
                    end
                end
                default: ;
            endcase
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working variables and schedule window
    always_ff @(posedge i_clk) begin
        if ((r_state == S_LOADH) && (r_cnt != 3'd0)) begin
            r_work <= '{a: r_work.b, b: r_work.c, c: r_work.d, d: r_work.e, e: h_eff};
        end else if (r_state == S_ROUND) begin
            r_work <= round_next;
        end
        if (r_state == S_ROUND) begin
            for (int i = 0; i < BUF_WORDS - 1; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[BUF_WORDS-1] <= w_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_digest_word <= h_eff;
            r_word_index  <= r_oidx;
            r_last_word   <= (r_oidx == 3'(CHAIN_WORDS - 1));
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_digest_word = r_digest_word;
    assign o_word_index  = r_word_index;
    assign o_last_word   = r_last_word;

    `SDE_ASSERT_IMP(a_round_range, r_state == S_ROUND, r_t < 7'(ROUNDS), "round count overran")
    `SDE_ASSERT_IMP(a_add_align, (r_state == S_ADD) && (r_cnt != 3'd0), r_crd_idx == (r_cnt - 3'd1), "chain write misaligned")
    `SDE_ASSERT_NXT(a_full_block, in_acc && i_byte_valid && (r_fill == 6'd63), r_state == S_LOADH, "full block not compressed")
    `SDE_ASSERT_IMP(a_last_tag, r_out_valid, r_last_word == (r_word_index == 3'(CHAIN_WORDS - 1)), "last word flag mismatch")

endmodule

// ===== rtl/core/sha1de_round.sv =====
// ----------------------------------------------------------------------------
// SHA-1 round step
// One compression round: f and K by round range, then the five-word rotate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1de_round (
    input  sha1de_pkg::t_abcde i_cur,
    input  logic [31:0]        i_w,
    input  logic [6:0]         i_round,
    output sha1de_pkg::t_abcde o_next
);
    import sha1de_pkg::*;

    logic [31:0] f;
    logic [31:0] k;
    logic [31:0] tmp;

    always_comb begin
        if (i_round < 7'd20) begin
            f = (i_cur.b & i_cur.c) | (~i_cur.b & i_cur.d);
            k = 32'h5A82_7999;
        end else if (i_round < 7'd40) begin
            f = i_cur.b ^ i_cur.c ^ i_cur.d;
            k = 32'h6ED9_EBA1;
        end else if (i_round < 7'd60) begin
            f = (i_cur.b & i_cur.c) | (i_cur.b & i_cur.d) | (i_cur.c & i_cur.d);
            k = 32'h8F1B_BCDC;
        end else begin
            f = i_cur.b ^ i_cur.c ^ i_cur.d;
            k = 32'hCA62_C1D6;
        end
    end

    assign tmp = rotl(i_cur.a, 5) + f + i_cur.e + k + i_w;

    always_comb begin
        o_next.a = tmp;
        o_next.b = i_cur.a;
        o_next.c = rotl(i_cur.b, 30);
        o_next.d = i_cur.c;
        o_next.e = i_cur.d;
    end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// SHA-1 digest engine core testbench
// Feeds byte-serial messages, predicts each five-word digest on the fly and
// compares every digest word against it under random valid/stall pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 250;

    localparam logic [31:0] IV_WORDS [0:4] = '{
        32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
    };
    localparam logic [31:0] K_CH  = 32'h5A82_7999;
    localparam logic [31:0] K_PA1 = 32'h6ED9_EBA1;
    localparam logic [31:0] K_MAJ = 32'h8F1B_BCDC;
    localparam logic [31:0] K_PA2 = 32'hCA62_C1D6;
    localparam logic [7:0]  PAD_MARK   = 8'h80;
    localparam int          LEN_OFFSET = 56;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_byte_valid = 1'b0;
    logic        i_end_of_message = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    // predicted engine state
    logic [31:0] hash_chain [0:4];
    logic [7:0]  hash_block [0:63];
    int          hash_fill;
    logic [60:0] hash_len_bytes;

    t_digest_beat digest_expect_q [$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold_cycles = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    int message_bytes_sent = 0;

    sha1_digest_engine_core u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_data_byte      (i_data_byte),
        .i_byte_valid     (i_byte_valid),
        .i_end_of_message (i_end_of_message),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_digest_word    (o_digest_word),
        .o_word_index     (o_word_index),
        .o_last_word      (o_last_word)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("sha1_digest_engine_core: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic void hash_clear();
        int i;
        for (i = 0; i < 5; i++) hash_chain[i] = IV_WORDS[i];
        for (i = 0; i < 64; i++) hash_block[i] = 8'h00;
        hash_fill = 0;
        hash_len_bytes = '0;
    endfunction

    function automatic void hash_compress();
        logic [31:0] w [0:79];
        logic [31:0] a, b, c, d, e, f, k, t;
        int i;
        for (i = 0; i < 16; i++)
            w[i] = {hash_block[4*i], hash_block[4*i+1], hash_block[4*i+2], hash_block[4*i+3]};
        for (i = 16; i < 80; i++) begin
            t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
            w[i] = {t[30:0], t[31]};
        end
        a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2];
        d = hash_chain[3]; e = hash_chain[4];
        for (i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d);
                k = K_CH;
            end else if (i < 40) begin
                f = b ^ c ^ d;
                k = K_PA1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_MAJ;
            end else begin
                f = b ^ c ^ d;
                k = K_PA2;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[i];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        hash_chain[0] += a; hash_chain[1] += b; hash_chain[2] += c;
        hash_chain[3] += d; hash_chain[4] += e;
    endfunction

    // pad, append bit length, queue the five digest words, start over
    function automatic void hash_finish();
        logic [63:0] bit_len;
        t_digest_beat beat;
        int pos;
        int i;
        bit_len = {hash_len_bytes, 3'b000};
        pos = hash_fill;
        hash_block[pos] = PAD_MARK;
        pos++;
        if (pos > LEN_OFFSET) begin
            while (pos < 64) begin
                hash_block[pos] = 8'h00;
                pos++;
            end
            hash_compress();
            pos = 0;
        end
        while (pos < LEN_OFFSET) begin
            hash_block[pos] = 8'h00;
            pos++;
        end
        for (i = 0; i < 8; i++) hash_block[LEN_OFFSET + i] = bit_len[8*(7-i) +: 8];
        hash_compress();
        for (i = 0; i < 5; i++) begin
            beat.word  = hash_chain[i];
            beat.index = 3'(i);
            beat.last  = (i == 4);
            digest_expect_q = {digest_expect_q, beat};
        end
        hash_clear();
    endfunction

    function automatic void hash_absorb(input logic [7:0] data, input logic bv, input logic eom);
        if (bv) begin
            hash_block[hash_fill] = data;
            hash_fill++;
            hash_len_bytes++;
            if (hash_fill == 64) begin
                hash_compress();
                hash_fill = 0;
            end
        end
        if (eom) hash_finish();
    endfunction

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("%0t ERROR %s: got %h, want %h", $realtime, what, got, want);
    endtask

    always @(posedge i_clk) begin : digest_check
        t_digest_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (digest_expect_q.size() == 0) begin
                report_mismatch("digest word with none pending", o_digest_word, 32'h0);
            end else begin
                want = digest_expect_q.pop_front();
                if (o_digest_word !== want.word)
                    report_mismatch("digest_word", o_digest_word, want.word);
                if (o_word_index !== want.index)
                    report_mismatch("word_index", 32'(o_word_index), 32'(want.index));
                if (o_last_word !== want.last)
                    report_mismatch("last_word", 32'(o_last_word), 32'(want.last));
            end
        end
    end

    // receiver: long hold-off when requested, else random stall
    always @(negedge i_clk) begin
        if (rx_hold_cycles > 0) begin
            rx_hold_cycles--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic send_word(input logic [7:0] data, input logic bv, input logic eom);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_data_byte      <= data;
        i_byte_valid     <= bv;
        i_end_of_message <= eom;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        hash_absorb(data, bv, eom);
    endtask

    task automatic release_input();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_digests_drained();
        while (digest_expect_q.size() != 0) @(posedge i_clk);
    endtask

    // one message of random bytes; noise words carry no byte and no end
    task automatic feed_message(input int len, input bit end_alone, input int noise_pct);
        int i;
        for (i = 0; i < len; i++) begin
            while ($urandom_range(99) < noise_pct)
                send_word(8'($urandom), 1'b0, 1'b0);
            send_word(8'($urandom), 1'b1, (i == len - 1) && !end_alone);
            message_bytes_sent++;
        end
        if (len == 0 || end_alone) begin
            send_word(8'($urandom), 1'b0, 1'b1);
            message_bytes_sent++;
        end
    endtask

    // short messages half the time, else lengths at the padding boundaries or up to 140
    function automatic int pick_length();
        int edges [0:9] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
        int sel;
        sel = $urandom_range(9);
        if (sel < 5)
            return $urandom_range(12, 0);
        else if (sel < 8)
            return edges[$urandom_range(9)];
        return $urandom_range(140, 13);
    endfunction

    task automatic test_directed_cases();
        send_word(8'h5A, 1'b0, 1'b1);                 // empty message
        send_word(8'h61, 1'b1, 1'b0);                 // "abc", end with last byte
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);
        send_word(8'hFF, 1'b0, 1'b0);                 // ignored words
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'h61, 1'b1, 1'b0);                 // "ab", then end alone
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'hFF, 1'b0, 1'b1);
        send_word(8'hFF, 1'b1, 1'b1);                 // single byte with end
        send_word(8'h00, 1'b1, 1'b1);
        send_word(8'h00, 1'b0, 1'b1);                 // back-to-back empty
        send_word(8'hA5, 1'b0, 1'b1);
    endtask

    task automatic test_random_messages(input int tx_pct, input int rx_pct, input int n_words);
        int stop_at;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        stop_at = message_bytes_sent + n_words;
        while (message_bytes_sent < stop_at)
            feed_message(pick_length(), $urandom_range(99) < 30, 8);
    endtask

    // receiver frozen long enough for the engine to back up into its input
    task automatic test_output_backpressure();
        rx_hold_cycles = 700;
        feed_message(3, 1'b0, 0);
        feed_message(70, 1'b0, 0);
        feed_message(0, 1'b1, 0);
        feed_message(5, 1'b1, 0);
    endtask

    task automatic test_drain_pause();
        feed_message($urandom_range(20, 1), 1'b0, 5);
        release_input();
        wait_digests_drained();
        feed_message(64, 1'b1, 5);
        release_input();
        wait_digests_drained();
        feed_message(0, 1'b1, 0);
    endtask

    initial begin
        hash_clear();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 27;
        rx_idle_pct = 52;
        test_directed_cases();
        test_random_messages(27, 52, 50);
        test_output_backpressure();
        test_random_messages(52, 27, 50);
        test_drain_pause();
        test_random_messages(0, 0, 50);

        release_input();
        wait_digests_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("sha1_digest_engine_core: match");
        else
            $display("sha1_digest_engine_core: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/sha1de_pkg.sv
rtl/core/sha1de_round.sv
rtl/core/sha1_digest_engine_core.sv
test/testbench.sv
